>>> design/pida_pkg.sv
// Package for the positional insert/delete array: opcodes, result status
// codes, row commands and the control struct sent to every cell. No dependencies.
package pida_pkg;

	localparam int OP_W     = 2;
	localparam int POS_W    = 7;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 6;
	localparam int COUNT_W  = 7;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT   = 2'd0,
		OP_DELETE   = 2'd1,
		OP_TRAVERSE = 2'd2,
		OP_NONE     = 2'd3
	} op_e_t;

	localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd3;

	typedef enum logic [1:0] {
		ROW_HOLD,
		ROW_INSERT,
		ROW_DELETE,
		ROW_ROTATE
	} row_op_t;

	typedef enum logic {
		S_IDLE,
		S_TRAV
	} state_t;

	// command broadcast along the row of cells
	typedef struct packed {
		row_op_t             op;
		logic [POS_W-1:0]    pos;
		logic [COUNT_W-1:0]  tail;
		logic [DATA_W-1:0]   elem;
	} row_ctrl_t;

endpackage

>>> design/pida_cell.sv
// One cell of the list row: holds one element; loads from its neighbors, the head or the command.
// Depends on pida_pkg for the row command struct.
module pida_cell
	import pida_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  row_ctrl_t         ctrl,
	input  logic [DATA_W-1:0] lo,
	input  logic [DATA_W-1:0] hi,
	input  logic [DATA_W-1:0] head,
	output logic [DATA_W-1:0] value
);

	localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

	logic [DATA_W-1:0] value_q;
	logic [DATA_W-1:0] value_d;

	always_comb begin
		value_d = value_q;
		case (ctrl.op)
			ROW_INSERT: begin
				if (MY_IDX == ctrl.pos) begin
					value_d = ctrl.elem;
				end else if (MY_IDX > ctrl.pos) begin
					value_d = lo;
				end
			end
			ROW_DELETE: begin
				if (MY_IDX >= ctrl.pos) begin
					value_d = hi;
				end
			end
			ROW_ROTATE: begin
				// wrap the head into the last occupied cell
				value_d = (MY_IDX == ctrl.tail) ? head : hi;
			end
			default: begin
				value_d = value_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;

endmodule

>>> design/positional_insert_delete_array.sv
// Positional insert/delete array list over a row of CAPACITY cells.
// A result is registered and appears on m_axis in the cycle after its item is accepted.
// Insert, delete and unused ops take one item per cycle and a traverse one stored
// element per cycle, rotating the row one place per result, unless m_axis stalls.
// Reset (arst_n low) clears the count, the sequencer and the output valid;
// cell contents are not reset and are only read after being written.
module positional_insert_delete_array
	import pida_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // op[1:0], position[8:2], element[40:9], zero fill
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // status[1:0], value[33:2], index[39:34],
	                                   // count[46:40], zero fill
	output logic        m_axis_tlast
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	// Sequencer and fill count
	state_t          state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [IW-1:0]   idx_q, idx_d;

	// Output register
	logic                m_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [DATA_W-1:0]   value_q;
	logic [INDEX_W-1:0]  index_q;
	logic [COUNT_W-1:0]  outcnt_q;
	logic                last_q;

	// Next output item
	logic                out_load;
	logic [STATUS_W-1:0] status_d;
	logic [DATA_W-1:0]   value_d;
	logic [INDEX_W-1:0]  index_d;
	logic [COUNT_W-1:0]  outcnt_d;
	logic                last_d;

	logic            load_ok;
	logic            in_acc;
	logic            trav_step;
	op_e_t           in_op;
	logic [POS_W-1:0] in_pos;
	logic [DATA_W-1:0] in_elem;
	logic [COUNT_W-1:0] count_ext;
	logic [CW-1:0]   count_m1;
	logic            is_full;
	logic            is_empty;
	logic            trav_last;
	row_ctrl_t       row_ctrl;

	logic [DATA_W-1:0] cell_val [CAPACITY];

	// Handshake: take an item only while idle and the output register can load
	assign load_ok       = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && load_ok;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign trav_step     = (state_q == S_TRAV) && load_ok;

	assign in_op   = op_e_t'(s_axis_tdata[1:0]);
	assign in_pos  = s_axis_tdata[8:2];
	assign in_elem = s_axis_tdata[40:9];

	assign count_ext = COUNT_W'(count_q);
	assign count_m1  = count_q - CW'(1);
	assign is_full   = (count_q == CW'(CAPACITY));
	assign is_empty  = (count_q == '0);
	assign trav_last = (idx_q == count_m1[IW-1:0]);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && in_op == OP_TRAVERSE && count_q > CW'(1)) begin
					state_d = S_TRAV;
				end
			end
			S_TRAV: begin
				if (trav_step && trav_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer: row command, count update, next result
	always_comb begin
		row_ctrl.op   = ROW_HOLD;
		row_ctrl.pos  = in_pos;
		row_ctrl.tail = COUNT_W'(count_m1);
		row_ctrl.elem = in_elem;
		count_d       = count_q;
		idx_d         = idx_q;
		out_load      = 1'b0;
		status_d      = STAT_OK;
		value_d       = '0;
		index_d       = '0;
		outcnt_d      = count_ext;
		last_d        = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					out_load = 1'b1;
					case (in_op)
						OP_INSERT: begin
							if (is_full) begin
								status_d = STAT_FULL;
							end else if (in_pos > count_ext) begin
								status_d = STAT_BADPOS;
							end else begin
								row_ctrl.op = ROW_INSERT;
								count_d     = count_q + CW'(1);
								outcnt_d    = count_ext + COUNT_W'(1);
							end
						end
						OP_DELETE: begin
							if (is_empty) begin
								status_d = STAT_EMPTY;
							end else if (in_pos >= count_ext) begin
								status_d = STAT_BADPOS;
							end else begin
								row_ctrl.op = ROW_DELETE;
								count_d     = count_m1;
								outcnt_d    = count_ext - COUNT_W'(1);
							end
						end
						OP_TRAVERSE: begin
							if (is_empty) begin
								status_d = STAT_EMPTY;
							end else begin
								// emit the head and rotate it to the tail
								row_ctrl.op = ROW_ROTATE;
								value_d     = cell_val[0];
								last_d      = (count_q == CW'(1));
								idx_d       = IW'(1);
							end
						end
						default: begin
							status_d = STAT_OK;
						end
					endcase
				end
			end
			S_TRAV: begin
				if (trav_step) begin
					out_load    = 1'b1;
					row_ctrl.op = ROW_ROTATE;
					value_d     = cell_val[0];
					index_d     = INDEX_W'(idx_q);
					last_d      = trav_last;
					idx_d       = idx_q + IW'(1);
				end
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// Row of cells; every cell sees its neighbors (zero past either end) and the head
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] lo_w;
		logic [DATA_W-1:0] hi_w;
		if (i == 0) begin : g_lo_edge
			assign lo_w = '0;
		end else begin : g_lo
			assign lo_w = cell_val[i-1];
		end
		if (i == CAPACITY - 1) begin : g_hi_edge
			assign hi_w = '0;
		end else begin : g_hi
			assign hi_w = cell_val[i+1];
		end
		pida_cell #(
			.IDX(i)
		) u_cell (
			.clk  (clk),
			.ctrl (row_ctrl),
			.lo   (lo_w),
			.hi   (hi_w),
			.head (cell_val[0]),
			.value(cell_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result payload until the next load
	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= status_d;
			value_q  <= value_d;
			index_q  <= index_d;
			outcnt_q <= outcnt_d;
			last_q   <= last_d;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tdata  = {1'b0, outcnt_q, index_q, value_q, status_q};

	// The fill count never passes the row length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	// A traverse run is only entered with at least two elements
	a_trav_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TRAV) |-> (count_q > CW'(1)))
		else $error("traverse running on a short list");

	// A result that is not the last of its item keeps the sequencer traversing
	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !last_d) |=> (state_q == S_TRAV))
		else $error("non-final result without traverse in progress");

	// The fill count holds for the whole traverse run
	a_trav_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TRAV) |=> $stable(count_q))
		else $error("fill count changed during traverse");

endmodule
